// ===== hw/rtl/wgas_pkg.sv =====
// Shared constants, codes and the power-on graph for the weighted graph store.
package wgas_pkg;

  localparam int VERTICES_DEF = 6;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_SET   = 1'b1;

  localparam logic [1:0] ST_NBR   = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Weight of the power-on graph between vertices a and b; zero means no edge.
  function automatic logic [15:0] init_weight(logic [3:0] a, logic [3:0] b);
    logic [7:0] key;
    logic [15:0] w;
    key = (a < b) ? {a, b} : {b, a};
    case (key) inside
      8'h12, 8'h13, 8'h14, 8'h23: w = 16'd1;
      8'h16:                      w = 16'd2;
      8'h35, 8'h55:               w = 16'd4;
      8'h56:                      w = 16'd3;
      default:                    w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/weighted_graph_adjacency_store_top.sv =====
// Top level of the weighted undirected graph store with its scan sequencer.
//
// The block keeps a weighted undirected graph over vertices 1..VERTICES as a
// weight matrix in a RAM; a zero weight means no edge. A command word enters
// on the input channel (in_valid / in_stall) and is taken only while the
// block is idle. A set command writes both matrix cells, one per write state,
// and gives no result word. A query reads the chosen row through the single
// RAM read port, one cell per cycle while the receiver does not stall, and
// gives one result word per neighbour in ascending vertex order, the last one
// marked; a vertex with no neighbours gives one word with the empty status.
// An invalid vertex gives a single error word from the final step through
// the output register and leaves the graph unchanged. Result words leave
// through a one-word output register (out_valid / out_stall); while the
// receiver stalls, the row scan waits and nothing is lost. Reset restores
// the power-on graph at once: each cell has a written flag, and a cell never
// written since reset reads as its power-on weight.
module weighted_graph_adjacency_store_top
  import wgas_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [3:0]         vertex_a,
  input  logic [3:0]         vertex_b,
  input  logic signed [15:0] new_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [3:0]         neighbour,
  output logic signed [15:0] weight_out,
  output logic               last_result
);

  localparam int CELLS = VERTICES * VERTICES;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(VERTICES + 2);
  localparam logic [3:0]    VMAX = 4'(VERTICES);
  localparam logic [CW-1:0] CMAX = CW'(VERTICES);

  typedef enum logic [2:0] {S_IDLE, S_WR1, S_WR2, S_SCAN, S_FIN} state_t;

  state_t          state;
  logic [CELLS-1:0] written;
  logic [AW-1:0]   wa1, wa2, raddr;
  logic [15:0]     wdat;
  logic [3:0]      row;
  logic [CW-1:0]   icol;
  logic            rpend, rwr;
  logic [3:0]      rcol;
  logic            pend_v;
  logic [3:0]      pend_col;
  logic [15:0]     pend_w;
  logic            err;

  logic            accept, va_ok, vb_ok;
  logic [AW-1:0]   base_a, base_b;
  logic [15:0]     rdata, rw;
  logic            hit, push_mid, advance, issue, scan_done, can_push;
  logic            load_out;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_push = !out_valid || !out_stall;

  assign va_ok  = (vertex_a != 4'd0) && (vertex_a <= VMAX);
  assign vb_ok  = (vertex_b != 4'd0) && (vertex_b <= VMAX);
  assign base_a = AW'((32'(vertex_a) - 32'd1) * 32'(VERTICES));
  assign base_b = AW'((32'(vertex_b) - 32'd1) * 32'(VERTICES));

  // A cell never written since reset holds its power-on weight.
  assign rw       = rwr ? rdata : init_weight(row, rcol);
  assign hit      = rw != 16'd0;
  assign push_mid = rpend && hit && pend_v;
  assign advance  = rpend && (!push_mid || can_push);
  assign issue    = (state == S_SCAN) && (icol <= CMAX) && (!rpend || advance);
  assign scan_done = (state == S_SCAN) && (icol > CMAX) && (!rpend || advance);

  // The output register takes a new word from the scan or from the final step.
  assign load_out = ((state == S_SCAN) && push_mid && advance) ||
                    ((state == S_FIN) && can_push);

  assign ram_we    = (state == S_WR1) || (state == S_WR2);
  assign ram_waddr = (state == S_WR1) ? wa1 : wa2;

  wgas_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wdat),
    .re   (issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      written   <= '0;
      rpend     <= 1'b0;
      pend_v    <= 1'b0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            row    <= vertex_a;
            raddr  <= base_a;
            icol   <= CW'(1);
            rpend  <= 1'b0;
            pend_v <= 1'b0;
            wa1    <= base_a + AW'(vertex_b - 4'd1);
            wa2    <= base_b + AW'(vertex_a - 4'd1);
            wdat   <= new_weight;
            if (command == CMD_SET) begin
              err   <= !(va_ok && vb_ok);
              state <= (va_ok && vb_ok) ? S_WR1 : S_FIN;
            end else begin
              err   <= !va_ok;
              state <= va_ok ? S_SCAN : S_FIN;
            end
          end
        end
        S_WR1: begin
          written[wa1] <= 1'b1;
          state        <= S_WR2;
        end
        S_WR2: begin
          written[wa2] <= 1'b1;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          if (advance && hit) begin
            // The held neighbour is not the last one, so it leaves now.
            if (pend_v) begin
              status      <= ST_NBR;
              neighbour   <= pend_col;
              weight_out  <= $signed(pend_w);
              last_result <= 1'b0;
            end
            pend_v   <= 1'b1;
            pend_col <= rcol;
            pend_w   <= rw;
          end
          if (!rpend || advance) begin
            rpend <= issue;
          end
          if (issue) begin
            raddr <= raddr + AW'(1);
            icol  <= icol + CW'(1);
            rcol  <= 4'(icol);
            rwr   <= written[raddr];
          end
          if (scan_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (can_push) begin
            last_result <= 1'b1;
            if (err) begin
              status     <= ST_ERR;
              neighbour  <= 4'd0;
              weight_out <= 16'sd0;
            end else if (pend_v) begin
              status     <= ST_NBR;
              neighbour  <= pend_col;
              weight_out <= $signed(pend_w);
            end else begin
              status     <= ST_EMPTY;
              neighbour  <= 4'd0;
              weight_out <= 16'sd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result word is never loaded over one the receiver still holds off.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (push_mid && advance) |-> can_push)
    else $error("result word overwritten while stalled");

  // Read data is only outstanding while a row scan runs.
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rpend |-> (state == S_SCAN))
    else $error("read outstanding outside a row scan");

  // A held neighbour is always a legal vertex number.
  a_pend_vertex: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> ((pend_col != 4'd0) && (pend_col <= VMAX)))
    else $error("held neighbour out of range");

  // Matrix writes stay inside the matrix.
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(ram_waddr) < CELLS))
    else $error("matrix write address out of range");

endmodule

// ===== hw/rtl/wgas_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module wgas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
